/* sv/dcu_pkg.sv */
// ----------------------------------------------------------------------------
// dcu_pkg
// Shared constants, codes and beat types of the disk controller command unit.
// ----------------------------------------------------------------------------
package dcu_pkg;

    // Geometry
    localparam int NUM_DRIVES       = 5;
    localparam int NUM_CYLINDERS    = 203;
    localparam int WORDS_PER_SECTOR = 321;

    // Field widths (fixed by the command and result formats)
    localparam int DRV_W  = 3;
    localparam int WORD_W = 16;
    localparam int CYL_W  = 8;
    localparam int SEC_W  = 3;
    localparam int SIDX_W = CYL_W + SEC_W;
    localparam int WC_W   = 9;
    localparam int STAT_W = 5;
    localparam int NS_W   = 2;

    // Drive select bits actually needed to index the per-drive state
    localparam int DIDX_W = (NUM_DRIVES > 1) ? $clog2(NUM_DRIVES) : 1;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_DRIVE_ONLINE = 1'b0;
    localparam logic REG_WRITE_LOCKED = 1'b1;

    // Status bit positions
    localparam int ST_DATA_ERR  = 4;
    localparam int ST_OP_DONE   = 3;
    localparam int ST_NOT_READY = 2;
    localparam int ST_BUSY      = 1;
    localparam int ST_HOME      = 0;

    // Modifier bit positions
    localparam int MOD_RESET   = 0;
    localparam int MOD_REVERSE = 2;
    localparam int MOD_VERIFY  = 7;

    typedef enum logic [2:0] {
        ACT_READ  = 3'd0,
        ACT_WRITE = 3'd1,
        ACT_SEEK  = 3'd2,
        ACT_SENSE = 3'd3,
        ACT_DONE  = 3'd4
    } action_t;

    typedef enum logic [2:0] {
        FN_IDLE   = 3'd0,
        FN_READ   = 3'd1,
        FN_VERIFY = 3'd2,
        FN_WRITE  = 3'd3,
        FN_SEEK   = 3'd4,
        FN_FAILED = 3'd5
    } func_t;

    typedef enum logic [2:0] {
        RK_NONE  = 3'd0,
        RK_SENSE = 3'd1,
        RK_WRITE = 3'd2,
        RK_READ  = 3'd3,
        RK_DONE  = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        TM_NONE   = 2'd0,
        TM_CANCEL = 2'd1,
        TM_ROTATE = 2'd2,
        TM_SEEK   = 2'd3
    } timer_t;

    typedef struct packed {
        logic [2:0]        action;
        logic [DRV_W-1:0]  drive;
        logic [WORD_W-1:0] modifier;
        logic [WORD_W-1:0] iocc_address;
        logic [WORD_W-1:0] word_count;
    } cmd_t;

    typedef struct packed {
        logic [2:0]            result_kind;
        logic [WORD_W-1:0]     status_word;
        logic [SIDX_W-1:0]     sector_index;
        logic [WORD_W-1:0]     memory_address;
        logic [WC_W-1:0]       transfer_words;
        logic [1:0]            timer_action;
        logic [NUM_DRIVES-1:0] interrupt_pending;
    } rsp_t;

    typedef struct packed {
        logic [NUM_DRIVES-1:0] drive_online;
        logic [NUM_DRIVES-1:0] write_locked;
    } cfg_t;

endpackage

/* sv/dcu_cmd_if.sv */
// ----------------------------------------------------------------------------
// dcu_cmd_if
// Command channel: one I/O command or completion event per beat.
// ----------------------------------------------------------------------------
interface dcu_cmd_if;
    logic                       valid;
    logic                       ready;
    logic [2:0]                 action;
    logic [dcu_pkg::DRV_W-1:0]  drive;
    logic [dcu_pkg::WORD_W-1:0] modifier;
    logic [dcu_pkg::WORD_W-1:0] iocc_address;
    logic [dcu_pkg::WORD_W-1:0] word_count;

    modport source (
        output valid, action, drive, modifier, iocc_address, word_count,
        input  ready
    );

    modport sink (
        input  valid, action, drive, modifier, iocc_address, word_count,
        output ready
    );
endinterface

/* sv/dcu_rsp_if.sv */
// ----------------------------------------------------------------------------
// dcu_rsp_if
// Result channel: one status, transfer or completion result per beat.
// ----------------------------------------------------------------------------
interface dcu_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [2:0]                     result_kind;
    logic [dcu_pkg::WORD_W-1:0]     status_word;
    logic [dcu_pkg::SIDX_W-1:0]     sector_index;
    logic [dcu_pkg::WORD_W-1:0]     memory_address;
    logic [dcu_pkg::WC_W-1:0]       transfer_words;
    logic [1:0]                     timer_action;
    logic [dcu_pkg::NUM_DRIVES-1:0] interrupt_pending;

    modport source (
        output valid, result_kind, status_word, sector_index, memory_address,
               transfer_words, timer_action, interrupt_pending,
        input  ready
    );

    modport sink (
        input  valid, result_kind, status_word, sector_index, memory_address,
               transfer_words, timer_action, interrupt_pending,
        output ready
    );
endinterface

/* sv/dcu_cfg_regs.sv */
// ----------------------------------------------------------------------------
// dcu_cfg_regs
// APB register file: drive online mask and write protect mask.
// ----------------------------------------------------------------------------
module dcu_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [dcu_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [dcu_pkg::APB_DATA_W-1:0] pwdata,
    output logic [dcu_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    output dcu_pkg::cfg_t                  cfg
);

    logic [dcu_pkg::NUM_DRIVES-1:0] online_reg;
    logic [dcu_pkg::NUM_DRIVES-1:0] locked_reg;
    logic                           wr_en;
    logic                           reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    // registers sit on 4-byte boundaries; word select is the top address bit
    assign reg_sel = paddr[dcu_pkg::APB_ADDR_W-1];

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            online_reg <= '0;
            locked_reg <= '0;
        end
        else if (wr_en)
        begin
            if (reg_sel == dcu_pkg::REG_DRIVE_ONLINE)
                online_reg <= pwdata[dcu_pkg::NUM_DRIVES-1:0];
            else
                locked_reg <= pwdata[dcu_pkg::NUM_DRIVES-1:0];
        end
    end

    // read back
    always_comb
    begin
        prdata = '0;
        if (reg_sel == dcu_pkg::REG_DRIVE_ONLINE)
            prdata[dcu_pkg::NUM_DRIVES-1:0] = online_reg;
        else
            prdata[dcu_pkg::NUM_DRIVES-1:0] = locked_reg;
    end

    assign cfg.drive_online = online_reg;
    assign cfg.write_locked = locked_reg;

endmodule

/* sv/dcu_drive_engine.sv */
// ----------------------------------------------------------------------------
// dcu_drive_engine
// Per-drive state and the single-pass command decode that updates it.
// ----------------------------------------------------------------------------
module dcu_drive_engine (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          advance,
    input  dcu_pkg::cmd_t cmd,
    input  dcu_pkg::cfg_t cfg,
    output dcu_pkg::rsp_t rsp
);

    localparam int ND = dcu_pkg::NUM_DRIVES;

    // per-drive state
    logic [dcu_pkg::CYL_W-1:0]  cyl_reg    [ND];
    logic [dcu_pkg::STAT_W-1:0] stat_reg   [ND];
    logic [dcu_pkg::NS_W-1:0]   nsec_reg   [ND];
    dcu_pkg::func_t             func_reg   [ND];
    logic [ND-1:0]              soft_reg;
    logic [ND-1:0]              hard_reg;
    logic [ND-1:0]              irq_reg;
    // saved read parameters (only read back while a read is pending)
    logic [dcu_pkg::WORD_W-1:0] saddr_reg  [ND];
    logic [dcu_pkg::WC_W-1:0]   swords_reg [ND];
    logic [dcu_pkg::SEC_W-1:0]  ssec_reg   [ND];

    logic [dcu_pkg::DIDX_W-1:0] d;
    logic                       in_range;
    logic                       online;
    logic                       locked;

    logic [dcu_pkg::CYL_W-1:0]  cyl_next;
    logic [dcu_pkg::STAT_W-1:0] stat_next;
    logic [dcu_pkg::NS_W-1:0]   nsec_next;
    dcu_pkg::func_t             func_next;
    logic                       soft_next;
    logic                       hard_next;
    logic [ND-1:0]              irq_next;
    logic                       save_en;

    logic [dcu_pkg::WC_W-1:0]   clamp_wc;
    logic                       wc_over;
    logic [dcu_pkg::SEC_W-1:0]  sec;
    logic [dcu_pkg::WORD_W-1:0] first_addr;
    logic [dcu_pkg::CYL_W-1:0]  steps;
    logic [dcu_pkg::CYL_W:0]    fwd_sum;
    logic [dcu_pkg::CYL_W-1:0]  seek_cyl;

    assign d        = cmd.drive[dcu_pkg::DIDX_W-1:0];
    assign in_range = {1'b0, cmd.drive} < (dcu_pkg::DRV_W+1)'(ND);
    assign online   = cfg.drive_online[d];
    assign locked   = cfg.write_locked[d];

    // word count clamp, sector and first data word
    assign wc_over    = cmd.word_count > dcu_pkg::WORD_W'(dcu_pkg::WORDS_PER_SECTOR);
    assign clamp_wc   = wc_over ? dcu_pkg::WC_W'(dcu_pkg::WORDS_PER_SECTOR)
                                : cmd.word_count[dcu_pkg::WC_W-1:0];
    assign sec        = cmd.modifier[dcu_pkg::SEC_W-1:0];
    assign first_addr = cmd.iocc_address + dcu_pkg::WORD_W'(1);

    // seek target, saturating at both end cylinders
    assign steps   = cmd.iocc_address[dcu_pkg::CYL_W-1:0];
    assign fwd_sum = {1'b0, cyl_reg[d]} + {1'b0, steps};
    always_comb
    begin
        if (cmd.modifier[dcu_pkg::MOD_REVERSE])
            seek_cyl = (steps >= cyl_reg[d]) ? '0 : cyl_reg[d] - steps;
        else if (fwd_sum >= (dcu_pkg::CYL_W+1)'(dcu_pkg::NUM_CYLINDERS))
            seek_cyl = dcu_pkg::CYL_W'(dcu_pkg::NUM_CYLINDERS - 1);
        else
            seek_cyl = fwd_sum[dcu_pkg::CYL_W-1:0];
    end

    // command decode: next state of the addressed drive and the result
    always_comb
    begin
        cyl_next  = cyl_reg[d];
        stat_next = stat_reg[d];
        nsec_next = nsec_reg[d];
        func_next = func_reg[d];
        soft_next = soft_reg[d];
        hard_next = hard_reg[d];
        irq_next  = irq_reg;
        save_en   = 1'b0;
        rsp       = '0;

        if (in_range)
        begin
            if (cmd.action != dcu_pkg::ACT_DONE)
                soft_next = 1'b0;

            case (dcu_pkg::action_t'(cmd.action))
                dcu_pkg::ACT_READ, dcu_pkg::ACT_WRITE:
                begin
                    rsp.timer_action = dcu_pkg::TM_CANCEL;
                    if (!online)
                        func_next = dcu_pkg::FN_FAILED;
                    else if (cmd.action == dcu_pkg::ACT_WRITE && locked)
                    begin
                        stat_next[dcu_pkg::ST_DATA_ERR] = 1'b1;
                        hard_next = 1'b1;
                        func_next = dcu_pkg::FN_FAILED;
                    end
                    else
                    begin
                        stat_next[dcu_pkg::ST_BUSY] = 1'b1;
                        if (cmd.word_count != '0)
                        begin
                            rsp.timer_action = dcu_pkg::TM_ROTATE;
                            if (wc_over)
                                soft_next = 1'b1;
                            if (cmd.action == dcu_pkg::ACT_WRITE)
                            begin
                                rsp.result_kind    = dcu_pkg::RK_WRITE;
                                rsp.sector_index   = {cyl_reg[d], sec};
                                rsp.memory_address = first_addr;
                                rsp.transfer_words = clamp_wc;
                                func_next          = dcu_pkg::FN_WRITE;
                            end
                            else if (!cmd.modifier[dcu_pkg::MOD_VERIFY])
                            begin
                                save_en   = 1'b1;
                                func_next = dcu_pkg::FN_READ;
                            end
                            else
                                func_next = dcu_pkg::FN_VERIFY;
                        end
                    end
                end

                dcu_pkg::ACT_SEEK:
                begin
                    rsp.timer_action = dcu_pkg::TM_CANCEL;
                    if (!online)
                        func_next = dcu_pkg::FN_FAILED;
                    else if (steps != '0)
                    begin
                        cyl_next  = seek_cyl;
                        func_next = dcu_pkg::FN_SEEK;
                        stat_next[dcu_pkg::ST_BUSY] = 1'b1;
                        rsp.timer_action = dcu_pkg::TM_SEEK;
                    end
                end

                dcu_pkg::ACT_SENSE:
                begin
                    stat_next[dcu_pkg::ST_HOME]      = 1'b0;
                    stat_next[dcu_pkg::ST_NOT_READY] = 1'b0;
                    if (hard_reg[d] || stat_reg[d][dcu_pkg::ST_BUSY] || !online)
                        stat_next[dcu_pkg::ST_NOT_READY] = 1'b1;
                    else if (cyl_reg[d] == '0)
                        stat_next[dcu_pkg::ST_HOME] = 1'b1;
                    nsec_next       = nsec_reg[d] + dcu_pkg::NS_W'(1);
                    rsp.result_kind = dcu_pkg::RK_SENSE;
                    rsp.status_word = {stat_next,
                                       (dcu_pkg::WORD_W-dcu_pkg::STAT_W-dcu_pkg::NS_W)'(0),
                                       nsec_next};
                    if (cmd.modifier[dcu_pkg::MOD_RESET])
                    begin
                        stat_next[dcu_pkg::ST_OP_DONE]  = 1'b0;
                        stat_next[dcu_pkg::ST_DATA_ERR] = 1'b0;
                        irq_next[d] = 1'b0;
                    end
                end

                dcu_pkg::ACT_DONE:
                begin
                    if (func_reg[d] != dcu_pkg::FN_IDLE)
                    begin
                        stat_next[dcu_pkg::ST_BUSY]    = 1'b0;
                        stat_next[dcu_pkg::ST_OP_DONE] = 1'b1;
                        if (soft_reg[d] || hard_reg[d])
                        begin
                            stat_next[dcu_pkg::ST_DATA_ERR] = 1'b1;
                            soft_next = 1'b0;
                        end
                        irq_next[d] = 1'b1;
                        if (func_reg[d] == dcu_pkg::FN_READ)
                        begin
                            rsp.result_kind    = dcu_pkg::RK_READ;
                            rsp.sector_index   = {cyl_reg[d], ssec_reg[d]};
                            rsp.memory_address = saddr_reg[d];
                            rsp.transfer_words = swords_reg[d];
                        end
                        else
                            rsp.result_kind = dcu_pkg::RK_DONE;
                        func_next = dcu_pkg::FN_IDLE;
                    end
                end

                default:
                begin
                    rsp.result_kind = dcu_pkg::RK_NONE;
                end
            endcase
        end

        rsp.interrupt_pending = irq_next;
    end

    // state update for the addressed drive
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ND; i++)
            begin
                cyl_reg[i]  <= '0;
                stat_reg[i] <= '0;
                nsec_reg[i] <= '0;
                func_reg[i] <= dcu_pkg::FN_IDLE;
            end
            soft_reg <= '0;
            hard_reg <= '0;
            irq_reg  <= '0;
        end
        else if (advance)
        begin
            irq_reg <= irq_next;
            if (in_range)
            begin
                cyl_reg[d]  <= cyl_next;
                stat_reg[d] <= stat_next;
                nsec_reg[d] <= nsec_next;
                func_reg[d] <= func_next;
                soft_reg[d] <= soft_next;
                hard_reg[d] <= hard_next;
            end
        end
    end

    // saved read parameters
    always_ff @(posedge clk)
    begin
        if (advance && in_range && save_en)
        begin
            saddr_reg[d]  <= first_addr;
            swords_reg[d] <= clamp_wc;
            ssec_reg[d]   <= sec;
        end
    end

endmodule

/* sv/disk_controller_command_unit.sv */
// ----------------------------------------------------------------------------
// disk_controller_command_unit
// Multi-drive disk controller command unit with APB configuration.
// ----------------------------------------------------------------------------
// Every command beat yields exactly one result beat. A beat is captured in an
// input register, decoded combinationally against the addressed drive's state,
// and its result lands in an output register, so a new command is taken every
// cycle unless the result register holds a result not yet taken. The per-drive
// state sits in flip-flops and is updated in the same cycle that produces the
// result, so the following command always sees it. Drive online and write
// protect masks are written through the APB port at byte addresses 0 and 4
// and must only change while no command is in flight.
module disk_controller_command_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [dcu_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [dcu_pkg::APB_DATA_W-1:0] pwdata,
    output logic [dcu_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    dcu_cmd_if.sink                        cmd,
    dcu_rsp_if.source                      rsp
);

    dcu_pkg::cfg_t cfg;
    dcu_pkg::cmd_t cmd_beat;
    dcu_pkg::cmd_t cmd_reg;
    dcu_pkg::rsp_t rsp_next;
    dcu_pkg::rsp_t rsp_reg;
    logic          cmd_vld_reg;
    logic          rsp_vld_reg;
    logic          advance;

    dcu_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // flow control: the decode stage moves when the result register is free
    assign advance   = cmd_vld_reg && (!rsp_vld_reg || rsp.ready);
    assign cmd.ready = !cmd_vld_reg || advance;

    assign cmd_beat.action       = cmd.action;
    assign cmd_beat.drive        = cmd.drive;
    assign cmd_beat.modifier     = cmd.modifier;
    assign cmd_beat.iocc_address = cmd.iocc_address;
    assign cmd_beat.word_count   = cmd.word_count;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cmd_vld_reg <= 1'b0;
        else if (cmd.ready)
            cmd_vld_reg <= cmd.valid;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
            cmd_reg <= cmd_beat;
    end

    dcu_drive_engine u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .cmd     (cmd_reg),
        .cfg     (cfg),
        .rsp     (rsp_next)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_vld_reg <= 1'b0;
        else if (advance)
            rsp_vld_reg <= 1'b1;
        else if (rsp.ready)
            rsp_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            rsp_reg <= rsp_next;
    end

    assign rsp.valid             = rsp_vld_reg;
    assign rsp.result_kind       = rsp_reg.result_kind;
    assign rsp.status_word       = rsp_reg.status_word;
    assign rsp.sector_index      = rsp_reg.sector_index;
    assign rsp.memory_address    = rsp_reg.memory_address;
    assign rsp.transfer_words    = rsp_reg.transfer_words;
    assign rsp.timer_action      = rsp_reg.timer_action;
    assign rsp.interrupt_pending = rsp_reg.interrupt_pending;

endmodule

/* test/tb_disk_controller_command_unit.sv */
// ----------------------------------------------------------------------------
// tb_disk_controller_command_unit
// Self-checking bench for the disk controller command unit.
// ----------------------------------------------------------------------------
// A short table of directed commands covers reset state, offline and
// out-of-range drives, spare action codes, write protect, word-count
// clamping, seek saturation and read, verify and zero-count starts. Several
// random phases follow under different drive masks, mostly start/complete
// transactions per drive with unrelated commands mixed in. Every accepted
// command is run through a behavioral copy of the drive state, and the result
// beats are checked in order against it, field by field.
module tb_disk_controller_command_unit;
    import dcu_pkg::*;

    localparam int LIMIT        = 400000;
    localparam int LONG_HOLD    = 300;
    localparam int NUM_PHASES   = 7;
    localparam int PHASE_ITEMS  = 130;
    localparam int DRAIN_CYCLES = 4;
    localparam int DRV_MAX      = (1 << DRV_W) - 1;

    // action codes with no meaning to the block
    localparam logic [2:0] ACT_SPARE_LO = 3'd5;
    localparam logic [2:0] ACT_SPARE_HI = 3'd7;

    typedef struct {
        cfg_t cfg;
        cmd_t c;
        bit   typed;
        rsp_t want;
    } directed_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    dcu_cmd_if cmd_bus ();
    dcu_rsp_if rsp_bus ();

    disk_controller_command_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cmd     (cmd_bus),
        .rsp     (rsp_bus)
    );

    // Behavioral copy of the per-drive state and the drive masks
    logic [NUM_DRIVES-1:0] online_mask;
    logic [NUM_DRIVES-1:0] lock_mask;
    logic [CYL_W-1:0]      head_cyl     [NUM_DRIVES];
    logic [STAT_W-1:0]     drv_status   [NUM_DRIVES];
    logic [NS_W-1:0]       sector_count [NUM_DRIVES];
    func_t                 drv_func     [NUM_DRIVES];
    logic                  soft_err     [NUM_DRIVES];
    logic                  hard_err     [NUM_DRIVES];
    logic [WORD_W-1:0]     rd_addr      [NUM_DRIVES];
    logic [WC_W-1:0]       rd_words     [NUM_DRIVES];
    logic [SEC_W-1:0]      rd_sector    [NUM_DRIVES];
    logic [NUM_DRIVES-1:0] irq_bits;

    rsp_t          outstanding_results[$];
    directed_row_t directed_rows[$];
    cfg_t          active_cfg;
    bit            typed_check;
    rsp_t          typed_result;
    bit            cmd_gaps;
    bit            rsp_gaps;
    bit            long_hold_req;
    int            items_sent;
    int            errors;
    int            cycles;

    // Clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run-away guard
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT)
        begin
            $display("disk_controller_command_unit test failed");
            $finish;
        end
    end

    // Outcome of one command; updates the copy of the drive state
    function automatic rsp_t command_outcome(input cmd_t c);
        rsp_t              r;
        int                d;
        int                n;
        int                pos;
        int                steps;
        bit                online;
        bit                locked;
        logic [SEC_W-1:0]  sec;
        logic [WORD_W-1:0] first;
        r = '0;
        d = c.drive;
        if (d < NUM_DRIVES)
        begin
            online = online_mask[d];
            locked = lock_mask[d];
            if (c.action != ACT_DONE)
                soft_err[d] = 1'b0;
            case (c.action)
                ACT_READ, ACT_WRITE:
                begin
                    r.timer_action = TM_CANCEL;
                    if (!online)
                        drv_func[d] = FN_FAILED;
                    else if (c.action == ACT_WRITE && locked)
                    begin
                        drv_status[d][ST_DATA_ERR] = 1'b1;
                        hard_err[d] = 1'b1;
                        drv_func[d] = FN_FAILED;
                    end
                    else
                    begin
                        drv_status[d][ST_BUSY] = 1'b1;
                        if (c.word_count != '0)
                        begin
                            // count beyond one sector is clamped and flagged
                            if (c.word_count > WORDS_PER_SECTOR)
                            begin
                                soft_err[d] = 1'b1;
                                n = WORDS_PER_SECTOR;
                            end
                            else
                                n = c.word_count;
                            sec = c.modifier[SEC_W-1:0];
                            first = c.iocc_address + 16'd1;
                            r.timer_action = TM_ROTATE;
                            if (c.action == ACT_WRITE)
                            begin
                                r.result_kind = RK_WRITE;
                                r.sector_index = {head_cyl[d], sec};
                                r.memory_address = first;
                                r.transfer_words = WC_W'(n);
                                drv_func[d] = FN_WRITE;
                            end
                            else if (!c.modifier[MOD_VERIFY])
                            begin
                                rd_addr[d] = first;
                                rd_words[d] = WC_W'(n);
                                rd_sector[d] = sec;
                                drv_func[d] = FN_READ;
                            end
                            else
                                drv_func[d] = FN_VERIFY;
                        end
                    end
                end
                ACT_SEEK:
                begin
                    r.timer_action = TM_CANCEL;
                    if (!online)
                        drv_func[d] = FN_FAILED;
                    else
                    begin
                        steps = c.iocc_address[7:0];
                        if (steps != 0)
                        begin
                            // saturate at both end cylinders
                            pos = head_cyl[d];
                            if (c.modifier[MOD_REVERSE])
                                pos = (steps >= pos) ? 0 : pos - steps;
                            else if (pos + steps >= NUM_CYLINDERS)
                                pos = NUM_CYLINDERS - 1;
                            else
                                pos = pos + steps;
                            head_cyl[d] = CYL_W'(pos);
                            drv_func[d] = FN_SEEK;
                            drv_status[d][ST_BUSY] = 1'b1;
                            r.timer_action = TM_SEEK;
                        end
                    end
                end
                ACT_SENSE:
                begin
                    drv_status[d][ST_HOME] = 1'b0;
                    drv_status[d][ST_NOT_READY] = 1'b0;
                    if (hard_err[d] || drv_status[d][ST_BUSY] || !online)
                        drv_status[d][ST_NOT_READY] = 1'b1;
                    else if (head_cyl[d] == '0)
                        drv_status[d][ST_HOME] = 1'b1;
                    sector_count[d] = sector_count[d] + 2'd1;
                    r.result_kind = RK_SENSE;
                    r.status_word = {drv_status[d], 9'd0, sector_count[d]};
                    if (c.modifier[MOD_RESET])
                    begin
                        drv_status[d][ST_OP_DONE] = 1'b0;
                        drv_status[d][ST_DATA_ERR] = 1'b0;
                        irq_bits[d] = 1'b0;
                    end
                end
                ACT_DONE:
                begin
                    if (drv_func[d] != FN_IDLE)
                    begin
                        drv_status[d][ST_BUSY] = 1'b0;
                        drv_status[d][ST_OP_DONE] = 1'b1;
                        if (soft_err[d] || hard_err[d])
                        begin
                            drv_status[d][ST_DATA_ERR] = 1'b1;
                            soft_err[d] = 1'b0;
                        end
                        irq_bits[d] = 1'b1;
                        if (drv_func[d] == FN_READ)
                        begin
                            r.result_kind = RK_READ;
                            r.sector_index = {head_cyl[d], rd_sector[d]};
                            r.memory_address = rd_addr[d];
                            r.transfer_words = rd_words[d];
                        end
                        else
                            r.result_kind = RK_DONE;
                        drv_func[d] = FN_IDLE;
                    end
                end
                default:
                begin
                    // spare action codes leave everything as it is
                end
            endcase
        end
        r.interrupt_pending = irq_bits;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    // Command acceptance feeds the prediction; result beats are checked in order
    always @(posedge clk)
    begin : scoreboard
        rsp_t want;
        if (rst_n)
        begin
            if (cmd_bus.valid && cmd_bus.ready)
            begin
                want = command_outcome(cmd_t'{cmd_bus.action, cmd_bus.drive,
                    cmd_bus.modifier, cmd_bus.iocc_address, cmd_bus.word_count});
                outstanding_results.push_back(typed_check ? typed_result : want);
            end
            if (rsp_bus.valid && rsp_bus.ready)
            begin
                if (outstanding_results.size() == 0)
                begin
                    $display("%0t: result beat with none expected, kind %0h",
                             $time, rsp_bus.result_kind);
                    errors++;
                end
                else
                begin
                    want = outstanding_results.pop_front();
                    check_field("result_kind", want.result_kind, rsp_bus.result_kind);
                    check_field("status_word", want.status_word, rsp_bus.status_word);
                    check_field("sector_index", want.sector_index, rsp_bus.sector_index);
                    check_field("memory_address", want.memory_address,
                                rsp_bus.memory_address);
                    check_field("transfer_words", want.transfer_words,
                                rsp_bus.transfer_words);
                    check_field("timer_action", want.timer_action, rsp_bus.timer_action);
                    check_field("interrupt_pending", want.interrupt_pending,
                                rsp_bus.interrupt_pending);
                end
            end
        end
    end

    // Mostly short stalls, now and then a long one
    function automatic int gap_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 85)
            return $urandom_range(1, 3);
        if (pick < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 50);
    endfunction

    // Result sink with random back-pressure and one long hold on request
    initial
    begin : result_sink
        int hold;
        hold = 0;
        rsp_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                rsp_bus.ready = 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                long_hold_req = 1'b0;
            end
            if (hold > 0)
            begin
                rsp_bus.ready = 1'b0;
                hold--;
            end
            else if (!rsp_gaps || $urandom_range(0, 99) < 75)
                rsp_bus.ready = 1'b1;
            else
            begin
                hold = gap_length() - 1;
                rsp_bus.ready = 1'b0;
            end
        end
    end

    // One command beat, after an optional idle gap
    task automatic send_command(input cmd_t c, input bit typed = 1'b0,
                                input rsp_t want = '0);
        int gap;
        gap = (cmd_gaps && $urandom_range(0, 99) < 40) ? gap_length() : 0;
        repeat (gap)
        begin
            @(negedge clk);
            cmd_bus.valid = 1'b0;
        end
        @(negedge clk);
        cmd_bus.valid = 1'b1;
        cmd_bus.action = c.action;
        cmd_bus.drive = c.drive;
        cmd_bus.modifier = c.modifier;
        cmd_bus.iocc_address = c.iocc_address;
        cmd_bus.word_count = c.word_count;
        typed_check = typed;
        typed_result = want;
        @(posedge clk);
        while (!cmd_bus.ready)
            @(posedge clk);
        items_sent++;
    endtask

    // Drop valid and wait for every expected result to come back
    task automatic settle_pipeline();
        @(negedge clk);
        cmd_bus.valid = 1'b0;
        while (outstanding_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic apb_transfer(input bit is_write, input logic [APB_ADDR_W-1:0] addr,
                                input logic [APB_DATA_W-1:0] wdata,
                                output logic [APB_DATA_W-1:0] rdata);
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = is_write;
        paddr = addr;
        pwdata = wdata;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic write_and_verify(input logic idx, input logic [NUM_DRIVES-1:0] value);
        logic [APB_DATA_W-1:0] rd;
        apb_transfer(1'b1, {idx, 2'b00}, APB_DATA_W'(value), rd);
        apb_transfer(1'b0, {idx, 2'b00}, '0, rd);
        if (rd !== APB_DATA_W'(value))
        begin
            $display("%0t: register %0d expected %0h actual %0h", $time, idx, value, rd);
            errors++;
        end
    endtask

    task automatic program_drive_masks(input cfg_t cfg);
        write_and_verify(REG_DRIVE_ONLINE, cfg.drive_online);
        write_and_verify(REG_WRITE_LOCKED, cfg.write_locked);
        online_mask = cfg.drive_online;
        lock_mask = cfg.write_locked;
        active_cfg = cfg;
    endtask

    function automatic int pick_drive();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(NUM_DRIVES, DRV_MAX);
        return $urandom_range(0, NUM_DRIVES - 1);
    endfunction

    function automatic cmd_t random_command();
        cmd_t c;
        int   pick;
        pick = $urandom_range(0, 99);
        if (pick < 20)
            c.action = ACT_READ;
        else if (pick < 35)
            c.action = ACT_WRITE;
        else if (pick < 50)
            c.action = ACT_SEEK;
        else if (pick < 72)
            c.action = ACT_SENSE;
        else if (pick < 95)
            c.action = ACT_DONE;
        else
            c.action = 3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
        c.drive = DRV_W'(pick_drive());
        c.modifier = WORD_W'($urandom);
        c.iocc_address = WORD_W'($urandom);
        // low byte doubles as the seek step count
        pick = $urandom_range(0, 99);
        if (pick < 10)
            c.iocc_address[7:0] = 8'd0;
        else if (pick < 75)
            c.iocc_address[7:0] = 8'($urandom_range(1, 24));
        pick = $urandom_range(0, 99);
        if (pick < 12)
            c.word_count = '0;
        else if (pick < 65)
            c.word_count = WORD_W'($urandom_range(1, WORDS_PER_SECTOR));
        else if (pick < 75)
            c.word_count = WORD_W'($urandom_range(WORDS_PER_SECTOR, WORDS_PER_SECTOR + 1));
        else
            c.word_count = WORD_W'($urandom);
        return c;
    endfunction

    // Start an operation on one drive, mix in other traffic, then complete it
    task automatic run_transaction();
        cmd_t c;
        int   d;
        int   pick;
        d = pick_drive();
        c = random_command();
        c.drive = DRV_W'(d);
        pick = $urandom_range(0, 9);
        c.action = (pick < 4) ? ACT_READ : (pick < 7) ? ACT_WRITE : ACT_SEEK;
        send_command(c);
        repeat ($urandom_range(0, 2))
            send_command(random_command());
        c = random_command();
        c.drive = DRV_W'(d);
        if ($urandom_range(0, 3) == 0)
        begin
            c.action = ACT_SENSE;
            send_command(c);
        end
        c.action = ACT_DONE;
        send_command(c);
        if ($urandom_range(0, 2) == 0)
        begin
            c.action = ACT_SENSE;
            send_command(c);
        end
    endtask

    function automatic void add_row(input cfg_t cfg, input logic [2:0] act, input int drv,
                                    input int mods, input int addr, input int wc,
                                    input bit typed = 1'b0, input rsp_t want = '0);
        directed_row_t row;
        row.cfg = cfg;
        row.c = cmd_t'{act, DRV_W'(drv), WORD_W'(mods), WORD_W'(addr), WORD_W'(wc)};
        row.typed = typed;
        row.want = want;
        directed_rows.push_back(row);
    endfunction

    initial
    begin : stimulus
        cfg_t off_cfg;
        cfg_t lock4_cfg;
        cfg_t cfg;
        int   phase_end;

        // quiet inputs and the state copy at reset
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cmd_bus.valid = 1'b0;
        cmd_bus.action = ACT_READ;
        cmd_bus.drive = '0;
        cmd_bus.modifier = '0;
        cmd_bus.iocc_address = '0;
        cmd_bus.word_count = '0;
        typed_check = 1'b0;
        typed_result = '0;
        cmd_gaps = 1'b1;
        rsp_gaps = 1'b1;
        long_hold_req = 1'b0;
        items_sent = 0;
        errors = 0;
        cycles = 0;
        online_mask = '0;
        lock_mask = '0;
        irq_bits = '0;
        for (int i = 0; i < NUM_DRIVES; i++)
        begin
            head_cyl[i] = '0;
            drv_status[i] = '0;
            sector_count[i] = '0;
            drv_func[i] = FN_IDLE;
            soft_err[i] = 1'b0;
            hard_err[i] = 1'b0;
            rd_addr[i] = '0;
            rd_words[i] = '0;
            rd_sector[i] = '0;
        end
        active_cfg = '0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        // Directed table: typed results where they follow at a glance
        off_cfg = cfg_t'{5'h00, 5'h00};
        lock4_cfg = cfg_t'{5'h1F, 5'h10};
        add_row(off_cfg, ACT_SENSE, 0, 0, 0, 0, 1'b1,
                rsp_t'{RK_SENSE, 16'h2001, 11'd0, 16'h0000, 9'd0, TM_NONE, 5'h00});
        add_row(off_cfg, ACT_READ, 1, 0, 'h0100, 5, 1'b1,
                rsp_t'{RK_NONE, 16'h0000, 11'd0, 16'h0000, 9'd0, TM_CANCEL, 5'h00});
        add_row(off_cfg, ACT_WRITE, DRV_MAX, 'hFFFF, 'hFFFF, 'hFFFF, 1'b1,
                rsp_t'{RK_NONE, 16'h0000, 11'd0, 16'h0000, 9'd0, TM_NONE, 5'h00});
        add_row(off_cfg, ACT_SPARE_LO + 3'd1, 2, 0, 0, 0, 1'b1,
                rsp_t'{RK_NONE, 16'h0000, 11'd0, 16'h0000, 9'd0, TM_NONE, 5'h00});
        add_row(off_cfg, ACT_DONE, 1, 0, 0, 0, 1'b1,
                rsp_t'{RK_DONE, 16'h0000, 11'd0, 16'h0000, 9'd0, TM_NONE, 5'h02});
        add_row(off_cfg, ACT_DONE, 3, 0, 0, 0, 1'b1,
                rsp_t'{RK_NONE, 16'h0000, 11'd0, 16'h0000, 9'd0, TM_NONE, 5'h02});
        add_row(lock4_cfg, ACT_WRITE, 4, 0, 0, 5, 1'b1,
                rsp_t'{RK_NONE, 16'h0000, 11'd0, 16'h0000, 9'd0, TM_CANCEL, 5'h02});
        add_row(lock4_cfg, ACT_DONE, 4, 0, 0, 0, 1'b1,
                rsp_t'{RK_DONE, 16'h0000, 11'd0, 16'h0000, 9'd0, TM_NONE, 5'h12});
        add_row(lock4_cfg, ACT_SENSE, 4, 'h0001, 0, 0, 1'b1,
                rsp_t'{RK_SENSE, 16'hE001, 11'd0, 16'h0000, 9'd0, TM_NONE, 5'h02});
        add_row(lock4_cfg, ACT_WRITE, 0, 'h0007, 'hFFFF, 'hFFFF, 1'b1,
                rsp_t'{RK_WRITE, 16'h0000, 11'd7, 16'h0000, 9'd321, TM_ROTATE, 5'h02});
        add_row(lock4_cfg, ACT_DONE, 0, 0, 0, 0, 1'b1,
                rsp_t'{RK_DONE, 16'h0000, 11'd0, 16'h0000, 9'd0, TM_NONE, 5'h03});
        add_row(lock4_cfg, ACT_READ, 2, 'h0005, 'h1233, WORDS_PER_SECTOR);
        add_row(lock4_cfg, ACT_DONE, 2, 0, 0, 0);
        add_row(lock4_cfg, ACT_SEEK, 2, 0, 'h00FF, 0);
        add_row(lock4_cfg, ACT_DONE, 2, 0, 0, 0);
        add_row(lock4_cfg, ACT_READ, 2, 'h0005, 'h0000, 1);
        add_row(lock4_cfg, ACT_DONE, 2, 0, 0, 0);
        add_row(lock4_cfg, ACT_SEEK, 2, 'h0004, 'h12FF, 0);
        add_row(lock4_cfg, ACT_SEEK, 3, 0, 'hFF00, 0);
        add_row(lock4_cfg, ACT_READ, 3, 'h0080, 'h4000, 10);
        add_row(lock4_cfg, ACT_DONE, 3, 0, 0, 0);
        add_row(lock4_cfg, ACT_READ, 1, 0, 'h8000, 0);
        add_row(lock4_cfg, ACT_SENSE, 1, 'hFFFF, 0, 0);
        add_row(lock4_cfg, ACT_SEEK, 0, 'h0004, 'h0003, 0);
        add_row(lock4_cfg, ACT_SENSE, 0, 0, 0, 0);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].cfg != active_cfg)
            begin
                settle_pipeline();
                program_drive_masks(directed_rows[i].cfg);
            end
            send_command(directed_rows[i].c, directed_rows[i].typed, directed_rows[i].want);
        end

        // Random phases, each under its own drive masks
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph)
                0: cfg = cfg_t'{5'h1F, 5'h00};
                1: cfg = cfg_t'{5'h1F, 5'h1F};
                2: cfg = cfg_t'{5'h00, 5'h00};
                3: cfg = cfg_t'{5'($urandom), 5'($urandom)};
                4: cfg = cfg_t'{5'h1F, 5'($urandom)};
                5: cfg = cfg_t'{5'($urandom) | 5'h13, 5'h00};
                default: cfg = cfg_t'{5'h1F, 5'h0A};
            endcase
            settle_pipeline();
            program_drive_masks(cfg);
            // phase 4 floods the block while results are held off
            cmd_gaps = (ph != 4) && (ph != 2);
            rsp_gaps = (ph != 5);
            if (ph == 4)
                long_hold_req = 1'b1;
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end)
            begin
                if ($urandom_range(0, 99) < 75)
                    run_transaction();
                else
                    send_command(random_command());
            end
        end

        settle_pipeline();
        if (errors == 0)
            $display("disk_controller_command_unit test passed");
        else
            $display("disk_controller_command_unit test failed");
        $finish;
    end

endmodule
